### rtl/light_gun_report_builder_macros.svh
// Assertion macros for the light gun report builder.
// Used by the top level only; depends on nothing else.
`ifndef LIGHT_GUN_REPORT_BUILDER_MACROS_SVH
`define LIGHT_GUN_REPORT_BUILDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LGRB_ASSERT_NOW(label, clk_sig, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!(rst_n)) \
		(ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LGRB_ASSERT_NEXT(label, clk_sig, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!(rst_n)) \
		(ante) |=> (cons)) else $error(msg);

`endif

### rtl/lgrb_pkg.sv
// Shared types and constants of the light gun report builder.
// Used by lgrb_pos_unit, light_gun_report_builder and tb_top; depends on nothing.
package lgrb_pkg;

	localparam int AIM_W    = 16;
	localparam int BTN_W    = 16;
	localparam int POS_W    = 15;
	localparam int SCALE_W  = 17;
	localparam int SPAN_W   = 10;
	localparam int ORIGIN_W = 17;
	localparam int CFG_W    = 17;
	localparam int CFG_IDX_W = 3;
	localparam int LEFT_W   = 4;
	localparam int ACC_W    = 51;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PROGRESSIVE = 3'd6;

	localparam logic [SCALE_W-1:0]         RST_SCALE_X     = 17'd59146;
	localparam logic [SCALE_W-1:0]         RST_SCALE_Y     = 17'd61931;
	localparam logic [SPAN_W-1:0]          RST_SPAN_WIDTH  = 10'd640;
	localparam logic [SPAN_W-1:0]          RST_SPAN_HEIGHT = 10'd240;
	localparam logic signed [ORIGIN_W-1:0] RST_ORIGIN_X    = 17'sd390;
	localparam logic signed [ORIGIN_W-1:0] RST_ORIGIN_Y    = 17'sd132;

	localparam int RECAL_REPORTS   = 4;
	localparam int TRIGGER_BIT     = 13;
	localparam int PROGRESSIVE_BIT = 8;

	localparam logic [BTN_W-1:0] TRIG_MASK = BTN_W'(1) << TRIGGER_BIT;
	localparam logic [BTN_W-1:0] PROG_MASK = BTN_W'(1) << PROGRESSIVE_BIT;

	// Half of 65535 * 65536, added before the truncating divide.
	localparam logic signed [ACC_W-1:0] ROUND_HALF = 51'sd2147450880;

	localparam logic [POS_W-1:0] POS_MIN = 15'd1;
	localparam logic [POS_W-1:0] POS_MAX = 15'd32767;

	typedef struct packed {
		logic span;
		logic scale;
		logic sum;
	} lgrb_step_t;

endpackage

### rtl/light_gun_report_builder.sv
// Top level of the light gun report builder: ports, registers, sequencer.
// Depends on lgrb_pkg, lgrb_pos_unit and light_gun_report_builder_macros.svh.
//
//   channel   handshake               payload
//   in        in_valid / in_ready     aim_x aim_y pressed offscreen reload_req recal_req
//   out       out_valid / out_ready   status_word pos_x pos_y
//   cfg       cfg_we                  cfg_idx cfg_wdata
//
// A word runs four steps per axis (span product, gain product, sum, quotient)
// and one to build the report before it is loaded into the output register.
// in_ready is high only while idle, so a new word is taken only after the last
// report is loaded. The next word is accepted while a finished report waits; the
// sequencer holds in its final state while the output register is still full.
// Reset restores the register defaults and clears the recalibration state.
`include "light_gun_report_builder_macros.svh"

module light_gun_report_builder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [lgrb_pkg::AIM_W-1:0]     aim_x,
	input  logic signed [lgrb_pkg::AIM_W-1:0]     aim_y,
	input  logic [lgrb_pkg::BTN_W-1:0]            pressed,
	input  logic                                  offscreen,
	input  logic                                  reload_req,
	input  logic                                  recal_req,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [lgrb_pkg::BTN_W-1:0]            status_word,
	output logic [lgrb_pkg::POS_W-1:0]            pos_x,
	output logic [lgrb_pkg::POS_W-1:0]            pos_y,
	input  logic                                  cfg_we,
	input  logic [lgrb_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [lgrb_pkg::CFG_W-1:0]            cfg_wdata
);
	import lgrb_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SPAN  = 6'b000010,
		ST_SCALE = 6'b000100,
		ST_SUM   = 6'b001000,
		ST_QUOT  = 6'b010000,
		ST_DONE  = 6'b100000
	} lgrb_state_t;

	lgrb_state_t state_q, state_next;
	logic axis_q;

	logic [SCALE_W-1:0]         scale_x_q, scale_y_q;
	logic [SPAN_W-1:0]          span_width_q, span_height_q;
	logic signed [ORIGIN_W-1:0] origin_x_q, origin_y_q;
	logic                       progressive_q;

	logic signed [AIM_W-1:0] aim_x_q, aim_y_q;
	logic [BTN_W-1:0]        pressed_q;
	logic                    offscreen_q, reload_q, recal_q;

	logic [POS_W-1:0]  calc_x_q, calc_y_q;
	logic [LEFT_W-1:0] recal_left_q;
	logic [POS_W-1:0]  held_x_q, held_y_q;

	logic             out_valid_q;
	logic [BTN_W-1:0] status_q;
	logic [POS_W-1:0] pos_x_q, pos_y_q;

	lgrb_step_t                 step;
	logic signed [AIM_W-1:0]    op_aim;
	logic [SPAN_W-1:0]          op_span;
	logic [SCALE_W-1:0]         op_scale;
	logic signed [ORIGIN_W-1:0] op_origin;
	logic [POS_W-1:0]           unit_pos;

	logic              accept, load_out, start;
	logic [LEFT_W-1:0] left_eff, left_next;
	logic [POS_W-1:0]  held_x_next, held_y_next, rep_x, rep_y;
	logic [BTN_W-1:0]  btn_eff, status_next;

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign load_out    = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign status_word = status_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q     <= RST_SCALE_X;
			scale_y_q     <= RST_SCALE_Y;
			span_width_q  <= RST_SPAN_WIDTH;
			span_height_q <= RST_SPAN_HEIGHT;
			origin_x_q    <= RST_ORIGIN_X;
			origin_y_q    <= RST_ORIGIN_Y;
			progressive_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SCALE_X:     scale_x_q     <= cfg_wdata;
				REG_SCALE_Y:     scale_y_q     <= cfg_wdata;
				REG_SPAN_WIDTH:  span_width_q  <= cfg_wdata[SPAN_W-1:0];
				REG_SPAN_HEIGHT: span_height_q <= cfg_wdata[SPAN_W-1:0];
				REG_ORIGIN_X:    origin_x_q    <= $signed(cfg_wdata);
				REG_ORIGIN_Y:    origin_y_q    <= $signed(cfg_wdata);
				REG_PROGRESSIVE: progressive_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_next = state_q;
		step       = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_next = ST_SPAN;
				end
			end
			ST_SPAN: begin
				step.span  = 1'b1;
				state_next = ST_SCALE;
			end
			ST_SCALE: begin
				step.scale = 1'b1;
				state_next = ST_SUM;
			end
			ST_SUM: begin
				step.sum   = 1'b1;
				state_next = ST_QUOT;
			end
			ST_QUOT: begin
				state_next = axis_q ? ST_DONE : ST_SPAN;
			end
			ST_DONE: begin
				if (load_out) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			if (accept) begin
				axis_q <= 1'b0;
			end else if (state_q == ST_QUOT) begin
				axis_q <= ~axis_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			aim_x_q     <= aim_x;
			aim_y_q     <= aim_y;
			pressed_q   <= pressed;
			offscreen_q <= offscreen;
			reload_q    <= reload_req;
			recal_q     <= recal_req;
		end
		if (state_q == ST_QUOT) begin
			if (axis_q) begin
				calc_y_q <= unit_pos;
			end else begin
				calc_x_q <= unit_pos;
			end
		end
	end

	always_comb begin
		if (axis_q) begin
			op_aim    = aim_y_q;
			op_span   = span_height_q;
			op_scale  = scale_y_q;
			op_origin = origin_y_q;
		end else begin
			op_aim    = aim_x_q;
			op_span   = span_width_q;
			op_scale  = scale_x_q;
			op_origin = origin_x_q;
		end
	end

	lgrb_pos_unit u_pos_unit (
		.clk    (clk),
		.step   (step),
		.aim    (op_aim),
		.span   (op_span),
		.scale  (op_scale),
		.origin (op_origin),
		.pos    (unit_pos)
	);

	always_comb begin
		start       = recal_q && (recal_left_q == '0);
		held_x_next = held_x_q;
		held_y_next = held_y_q;
		left_eff    = recal_left_q;
		if (start) begin
			held_x_next = offscreen_q ? '0 : calc_x_q;
			held_y_next = offscreen_q ? '0 : calc_y_q;
			left_eff    = LEFT_W'(RECAL_REPORTS);
		end
		if (left_eff != '0) begin
			left_next = left_eff - LEFT_W'(1);
			btn_eff   = pressed_q | TRIG_MASK;
			rep_x     = (left_next != '0) ? held_x_next : '0;
			rep_y     = (left_next != '0) ? held_y_next : '0;
		end else begin
			left_next = left_eff;
			btn_eff   = reload_q ? (pressed_q | TRIG_MASK) : pressed_q;
			rep_x     = (!offscreen_q && !reload_q) ? calc_x_q : '0;
			rep_y     = (!offscreen_q && !reload_q) ? calc_y_q : '0;
		end
		status_next = ~btn_eff | (progressive_q ? PROG_MASK : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recal_left_q <= '0;
			held_x_q     <= '0;
			held_y_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load_out) begin
				recal_left_q <= left_next;
				held_x_q     <= held_x_next;
				held_y_q     <= held_y_next;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= status_next;
			pos_x_q  <= rep_x;
			pos_y_q  <= rep_y;
		end
	end

	`LGRB_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !in_ready,
		"sequencer accepted a word without leaving idle")
	`LGRB_ASSERT_NEXT(a_report_loaded, clk, arst_n, load_out, out_valid && in_ready,
		"report load did not raise out_valid and return to idle")
	`LGRB_ASSERT_NEXT(a_recal_trigger, clk, arst_n, load_out && (recal_left_q != '0),
		!status_word[TRIGGER_BIT], "recalibration report lacks the trigger")
	`LGRB_ASSERT_NOW(a_left_bound, clk, arst_n, 1'b1,
		recal_left_q <= LEFT_W'(RECAL_REPORTS), "recalibration count out of range")

endmodule

### rtl/lgrb_pos_unit.sv
// Shared multiply, accumulate and rounding unit for one axis position.
// Depends on lgrb_pkg; sequenced by light_gun_report_builder.
module lgrb_pos_unit (
	input  logic                                  clk,
	input  lgrb_pkg::lgrb_step_t                  step,
	input  logic signed [lgrb_pkg::AIM_W-1:0]     aim,
	input  logic [lgrb_pkg::SPAN_W-1:0]           span,
	input  logic [lgrb_pkg::SCALE_W-1:0]          scale,
	input  logic signed [lgrb_pkg::ORIGIN_W-1:0]  origin,
	output logic [lgrb_pkg::POS_W-1:0]            pos
);
	import lgrb_pkg::*;

	logic signed [26:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [44:0] prod;
	logic [24:0]        half_term;
	logic signed [26:0] d_next;
	logic signed [26:0] d_q;
	logic signed [43:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] org_ext;
	logic signed [ACC_W-1:0] prod_ext;
	logic [14:0] q0;
	logic [16:0] rem;
	logic [15:0] quot;

	always_comb begin
		if (step.span) begin
			mul_a = $signed({11'b0, ~aim[AIM_W-1], aim[AIM_W-2:0]});
			mul_b = $signed({8'b0, span});
		end else begin
			mul_a = d_q;
			mul_b = $signed({1'b0, scale});
		end
		prod = mul_a * mul_b;
	end

	assign half_term = {span[SPAN_W-1:1], 16'b0} - 25'(span[SPAN_W-1:1]);
	assign d_next    = $signed(prod[26:0]) - $signed({2'b00, half_term});
	assign org_ext   = {{(ACC_W-ORIGIN_W){origin[ORIGIN_W-1]}}, origin};
	assign prod_ext  = {{(ACC_W-44){prod_q[43]}}, prod_q};

	always_ff @(posedge clk) begin
		if (step.span) begin
			d_q <= d_next;
		end
		if (step.scale) begin
			prod_q <= prod[43:0];
		end
		if (step.sum) begin
			acc_q <= prod_ext + (org_ext <<< 32) - (org_ext <<< 16) + ROUND_HALF;
		end
	end

	// The quotient by 65535 uses 65536 = 1 modulo 65535 and one correction.
	always_comb begin
		q0   = acc_q[46:32];
		rem  = {1'b0, acc_q[31:16]} + {2'b00, q0};
		quot = {1'b0, q0} + ((rem >= 17'd65535) ? 16'd1 : 16'd0);
		if (acc_q[ACC_W-1]) begin
			pos = POS_MIN;
		end else if (|acc_q[49:47]) begin
			pos = POS_MAX;
		end else if (quot == 16'd0) begin
			pos = POS_MIN;
		end else if (quot[15]) begin
			pos = POS_MAX;
		end else begin
			pos = quot[14:0];
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for light_gun_report_builder: random samples, register settings
// and stalls on both channels, each report checked against an in-bench prediction.
// Depends on lgrb_pkg and the light_gun_report_builder RTL.
module tb_top;
	import lgrb_pkg::*;

	typedef struct {
		logic signed [AIM_W-1:0] ax;
		logic signed [AIM_W-1:0] ay;
		logic [BTN_W-1:0]        btn;
		logic                    off;
		logic                    rel;
		logic                    rcal;
	} sample_t;

	typedef struct packed {
		logic [BTN_W-1:0] status;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
	} report_t;

	localparam longint POS_DIV   = 64'd4294901760;
	localparam longint POS_HALF  = 64'd2147450880;
	localparam int     HOLD_LONG = 400;
	localparam int     QUIET_MAX = 4000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [AIM_W-1:0] aim_x = '0;
	logic signed [AIM_W-1:0] aim_y = '0;
	logic [BTN_W-1:0]        pressed = '0;
	logic                    offscreen = 1'b0;
	logic                    reload_req = 1'b0;
	logic                    recal_req = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [BTN_W-1:0]        status_word;
	logic [POS_W-1:0]        pos_x;
	logic [POS_W-1:0]        pos_y;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_idx = '0;
	logic [CFG_W-1:0]        cfg_wdata = '0;

	light_gun_report_builder dut (.*);

	// Predictor copy of the registers and the recalibration state.
	logic [SCALE_W-1:0]         gain_x = RST_SCALE_X;
	logic [SCALE_W-1:0]         gain_y = RST_SCALE_Y;
	logic [SPAN_W-1:0]          width_span = RST_SPAN_WIDTH;
	logic [SPAN_W-1:0]          height_span = RST_SPAN_HEIGHT;
	logic signed [ORIGIN_W-1:0] org_x = RST_ORIGIN_X;
	logic signed [ORIGIN_W-1:0] org_y = RST_ORIGIN_Y;
	logic                       prog_mode = 1'b0;
	logic [LEFT_W-1:0]          recal_cnt = '0;
	logic [POS_W-1:0]           latch_x = '0;
	logic [POS_W-1:0]           latch_y = '0;

	sample_t pending_samples[$];
	report_t expected_reports[$];
	sample_t cur_sample;
	report_t got_report;
	report_t exp_report;

	bit gaps_on = 1'b1;
	bit stall_pending = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_cnt = 0;
	int quiet_cycles = 0;
	int errors = 0;
	int reports_seen = 0;
	int samples_sent = 0;
	int recal_starts = 0;
	int reload_cnt = 0;
	int offscreen_cnt = 0;
	int settings_used = 0;

	always #5 clk = ~clk;

	function automatic logic [POS_W-1:0] map_axis(logic signed [AIM_W-1:0] aim,
			logic [SPAN_W-1:0] span, logic [SCALE_W-1:0] gain,
			logic signed [ORIGIN_W-1:0] org);
		longint u;
		longint d;
		longint t;
		longint p;
		u = longint'({~aim[AIM_W-1], aim[AIM_W-2:0]});
		d = u * longint'(span) - longint'(span >> 1) * 65535;
		t = d * longint'(gain) + longint'(org) * POS_DIV;
		if (t >= 0) begin
			p = (t + POS_HALF) / POS_DIV;
		end else begin
			p = -((-t + POS_HALF) / POS_DIV);
		end
		if (p < 1) p = 1;
		if (p > 32767) p = 32767;
		return p[POS_W-1:0];
	endfunction

	function automatic report_t build_report(sample_t s);
		report_t r;
		logic [BTN_W-1:0] btn;
		btn = s.btn;
		r.x = '0;
		r.y = '0;
		if (s.rcal && recal_cnt == 0) begin
			recal_cnt = LEFT_W'(RECAL_REPORTS);
			recal_starts++;
			if (s.off) begin
				latch_x = '0;
				latch_y = '0;
			end else begin
				latch_x = map_axis(s.ax, width_span, gain_x, org_x);
				latch_y = map_axis(s.ay, height_span, gain_y, org_y);
			end
		end
		if (recal_cnt != 0) begin
			recal_cnt = recal_cnt - 1'b1;
			if (recal_cnt != 0) begin
				r.x = latch_x;
				r.y = latch_y;
			end
			btn = btn | TRIG_MASK;
		end else begin
			if (s.rel) btn = btn | TRIG_MASK;
			if (!s.off && !s.rel) begin
				r.x = map_axis(s.ax, width_span, gain_x, org_x);
				r.y = map_axis(s.ay, height_span, gain_y, org_y);
			end
		end
		r.status = ~btn | (prog_mode ? PROG_MASK : '0);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [AIM_W-1:0] pick_aim();
		case ($urandom_range(0, 9))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return AIM_W'($urandom_range(0, 128)) - 16'sd64;
			default: return AIM_W'($urandom);
		endcase
	endfunction

	function automatic sample_t make_sample();
		sample_t s;
		s.ax = pick_aim();
		s.ay = pick_aim();
		s.btn = BTN_W'($urandom);
		s.off = ($urandom_range(0, 99) < 12);
		s.rel = ($urandom_range(0, 99) < 12);
		s.rcal = ($urandom_range(0, 99) < 10);
		return s;
	endfunction

	// Sender: one word at a time, each with a gap drawn when it is presented and spent after it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_reports.push_back(build_report(cur_sample));
				samples_sent++;
				if (cur_sample.rel) reload_cnt++;
				if (cur_sample.off) offscreen_cnt++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					cur_sample = pending_samples.pop_front();
					aim_x <= cur_sample.ax;
					aim_y <= cur_sample.ay;
					pressed <= cur_sample.btn;
					offscreen <= cur_sample.off;
					reload_req <= cur_sample.rel;
					recal_req <= cur_sample.rcal;
					in_valid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each accepted report and throttles out_ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				reports_seen++;
				got_report = {status_word, pos_x, pos_y};
				if (expected_reports.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected report %0d: status %h x %0d y %0d",
							reports_seen, status_word, pos_x, pos_y);
				end else begin
					exp_report = expected_reports.pop_front();
					if (got_report.status !== exp_report.status ||
						got_report.x !== exp_report.x || got_report.y !== exp_report.y) begin
						errors++;
						if (errors <= 10)
							$display({"report %0d mismatch: status exp %h got %h, ",
								"x exp %0d got %0d, y exp %0d got %0d"}, reports_seen,
								exp_report.status, got_report.status, exp_report.x,
								got_report.x, exp_report.y, got_report.y);
					end
				end
				recv_gap = pick_gap();
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else if (stall_pending) begin
				stall_pending = 1'b0;
				hold_cnt = HOLD_LONG;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(pending_samples.size() == 0 && !in_valid && expected_reports.size() == 0))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_MAX) begin
				$display("timeout: no word moved for %0d cycles", QUIET_MAX);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_SCALE_X:     gain_x = val;
			REG_SCALE_Y:     gain_y = val;
			REG_SPAN_WIDTH:  width_span = val[SPAN_W-1:0];
			REG_SPAN_HEIGHT: height_span = val[SPAN_W-1:0];
			REG_ORIGIN_X:    org_x = val;
			REG_ORIGIN_Y:    org_y = val;
			REG_PROGRESSIVE: prog_mode = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input logic [CFG_W-1:0] gx, input logic [CFG_W-1:0] gy,
			input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
			input logic [CFG_W-1:0] ox, input logic [CFG_W-1:0] oy, input logic pg);
		set_reg(REG_SCALE_X, gx);
		set_reg(REG_SCALE_Y, gy);
		set_reg(REG_SPAN_WIDTH, sw);
		set_reg(REG_SPAN_HEIGHT, sh);
		set_reg(REG_ORIGIN_X, ox);
		set_reg(REG_ORIGIN_Y, oy);
		set_reg(REG_PROGRESSIVE, CFG_W'(pg));
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
		@(negedge clk);
	endtask

	task automatic push_sample(input logic signed [AIM_W-1:0] ax, input logic signed [AIM_W-1:0] ay,
			input logic [BTN_W-1:0] btn, input logic off, input logic rel, input logic rcal);
		sample_t s;
		s.ax = ax;
		s.ay = ay;
		s.btn = btn;
		s.off = off;
		s.rel = rel;
		s.rcal = rcal;
		pending_samples.push_back(s);
	endtask

	task automatic wait_idle();
		while (pending_samples.size() != 0 || in_valid || expected_reports.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic push_random(input int n);
		repeat (n) pending_samples.push_back(make_sample());
	endtask

	function automatic logic [CFG_W-1:0] pick_origin();
		if ($urandom_range(0, 3) == 0) return CFG_W'($urandom);
		return CFG_W'($urandom_range(0, 2400)) - CFG_W'(400);
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Reset defaults: extremes, offscreen, reload and recalibration sequences.
		push_sample(16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0, 1'b0);
		push_sample(-16'sd32768, -16'sd32768, 16'hFFFF, 1'b0, 1'b0, 1'b0);
		push_sample(16'sd32767, 16'sd32767, 16'h5555, 1'b0, 1'b0, 1'b0);
		push_sample(-16'sd1, 16'sd1, 16'hAAAA, 1'b0, 1'b0, 1'b0);
		push_sample(16'sd1200, -16'sd900, 16'h0F0F, 1'b1, 1'b0, 1'b0);
		push_sample(16'sd1200, -16'sd900, 16'hF0F0, 1'b0, 1'b1, 1'b0);
		push_sample(16'sd1200, -16'sd900, 16'h2000, 1'b1, 1'b1, 1'b0);
		push_sample(16'sd1000, -16'sd1000, 16'h0001, 1'b0, 1'b1, 1'b1);
		push_sample(-16'sd5000, 16'sd5000, 16'h0002, 1'b0, 1'b0, 1'b1);
		push_sample(16'sd32767, 16'sd32767, 16'h0004, 1'b0, 1'b1, 1'b0);
		push_sample(-16'sd32768, 16'sd0, 16'h0008, 1'b1, 1'b0, 1'b0);
		push_sample(16'sd0, 16'sd0, 16'hFFFF, 1'b0, 1'b0, 1'b0);
		push_sample(16'sd300, 16'sd300, 16'h1234, 1'b1, 1'b0, 1'b1);
		push_sample(16'sd300, 16'sd300, 16'h4321, 1'b0, 1'b0, 1'b0);
		push_sample(16'sd300, 16'sd300, 16'hDFFF, 1'b0, 1'b0, 1'b1);
		push_sample(16'sd300, 16'sd300, 16'h8000, 1'b0, 1'b0, 1'b0);
		push_sample(16'sd300, 16'sd300, 16'h8000, 1'b0, 1'b0, 1'b1);
		push_sample(-16'sd32768, 16'sd32767, 16'h0000, 1'b0, 1'b0, 1'b0);
		push_sample(-16'sd32768, 16'sd32767, 16'h0000, 1'b0, 1'b0, 1'b0);
		push_sample(-16'sd32768, 16'sd32767, 16'h0000, 1'b0, 1'b0, 1'b0);
		push_sample(-16'sd32768, 16'sd32767, 16'h0000, 1'b0, 1'b0, 1'b0);
		wait_idle();

		apply_setting(17'd131071, 17'd131071, 17'd1023, 17'd1023, 17'h10000, 17'h0FFFF, 1'b1);
		push_random(130);
		wait_idle();

		// Zero span and zero gain; the receiver stalls long enough to back up the input.
		apply_setting(17'd0, 17'd0, 17'd0, 17'd0, 17'd390, 17'd132, 1'b0);
		push_random(130);
		stall_pending = 1'b1;
		wait_idle();

		apply_setting(17'd65536, 17'd65536, 17'd1, 17'd1, 17'h18000, 17'd34815, 1'b1);
		push_random(130);
		wait_idle();

		gaps_on = 1'b0;
		apply_setting(17'd59146, 17'd61931, 17'd640, 17'd240, 17'h1FFFF, 17'd0, 1'b0);
		push_random(130);
		wait_idle();
		gaps_on = 1'b1;

		repeat (9) begin
			apply_setting(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom_range(0, 1023)),
				CFG_W'($urandom_range(0, 1023)), pick_origin(), pick_origin(),
				1'($urandom_range(0, 1)));
			push_random(135);
			wait_idle();
		end

		repeat (20) @(posedge clk);
		$display("Sent %0d samples over %0d register settings, %0d reports checked.",
			samples_sent, settings_used, reports_seen);
		$display("Covered %0d recalibration sequences, %0d reloads, %0d offscreen samples.",
			recal_starts, reload_cnt, offscreen_cnt);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d reports failed their check.", errors);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/lgrb_pkg.sv
rtl/lgrb_pos_unit.sv
rtl/light_gun_report_builder.sv
tb/sv/tb_top.sv
